### rtl/cpu6502dec_pkg.sv
// ----------------------------------------------------------------------------
// cpu6502dec_pkg
// Shared types, mnemonic and addressing mode codes, and the opcode table
// for the 6502 opcode decoder.
// ----------------------------------------------------------------------------
package cpu6502dec_pkg;

   typedef logic [5:0] mnemonic_type;
   typedef logic [4:0] mode_type;
   typedef logic [2:0] cycles_type;

   // Mnemonic codes, alphabetical from 1; 0 marks an unknown opcode
   localparam mnemonic_type MN_UNKNOWN = 6'd0;
   localparam mnemonic_type MN_ADC = 6'd1;
   localparam mnemonic_type MN_AND = 6'd2;
   localparam mnemonic_type MN_ASL = 6'd3;
   localparam mnemonic_type MN_BCC = 6'd4;
   localparam mnemonic_type MN_BCS = 6'd5;
   localparam mnemonic_type MN_BEQ = 6'd6;
   localparam mnemonic_type MN_BIT = 6'd7;
   localparam mnemonic_type MN_BMI = 6'd8;
   localparam mnemonic_type MN_BNE = 6'd9;
   localparam mnemonic_type MN_BPL = 6'd10;
   localparam mnemonic_type MN_BRK = 6'd11;
   localparam mnemonic_type MN_BVC = 6'd12;
   localparam mnemonic_type MN_BVS = 6'd13;
   localparam mnemonic_type MN_CLC = 6'd14;
   localparam mnemonic_type MN_CLD = 6'd15;
   localparam mnemonic_type MN_CLI = 6'd16;
   localparam mnemonic_type MN_CLV = 6'd17;
   localparam mnemonic_type MN_CMP = 6'd18;
   localparam mnemonic_type MN_CPX = 6'd19;
   localparam mnemonic_type MN_CPY = 6'd20;
   localparam mnemonic_type MN_DEC = 6'd21;
   localparam mnemonic_type MN_DEX = 6'd22;
   localparam mnemonic_type MN_DEY = 6'd23;
   localparam mnemonic_type MN_EOR = 6'd24;
   localparam mnemonic_type MN_INC = 6'd25;
   localparam mnemonic_type MN_INX = 6'd26;
   localparam mnemonic_type MN_INY = 6'd27;
   localparam mnemonic_type MN_JMP = 6'd28;
   localparam mnemonic_type MN_JSR = 6'd29;
   localparam mnemonic_type MN_LDA = 6'd30;
   localparam mnemonic_type MN_LDX = 6'd31;
   localparam mnemonic_type MN_LDY = 6'd32;
   localparam mnemonic_type MN_LSR = 6'd33;
   localparam mnemonic_type MN_NOP = 6'd34;
   localparam mnemonic_type MN_ORA = 6'd35;
   localparam mnemonic_type MN_PHA = 6'd36;
   localparam mnemonic_type MN_PHP = 6'd37;
   localparam mnemonic_type MN_PLA = 6'd38;
   localparam mnemonic_type MN_PLP = 6'd39;
   localparam mnemonic_type MN_ROL = 6'd40;
   localparam mnemonic_type MN_ROR = 6'd41;
   localparam mnemonic_type MN_RTI = 6'd42;
   localparam mnemonic_type MN_RTS = 6'd43;
   localparam mnemonic_type MN_SBC = 6'd44;
   localparam mnemonic_type MN_SEC = 6'd45;
   localparam mnemonic_type MN_SED = 6'd46;
   localparam mnemonic_type MN_SEI = 6'd47;
   localparam mnemonic_type MN_STA = 6'd48;
   localparam mnemonic_type MN_STX = 6'd49;
   localparam mnemonic_type MN_STY = 6'd50;
   localparam mnemonic_type MN_TAX = 6'd51;
   localparam mnemonic_type MN_TAY = 6'd52;
   localparam mnemonic_type MN_TSX = 6'd53;
   localparam mnemonic_type MN_TXA = 6'd54;
   localparam mnemonic_type MN_TXS = 6'd55;
   localparam mnemonic_type MN_TYA = 6'd56;

   // Addressing modes
   localparam mode_type MD_ACC  = 5'd0;
   localparam mode_type MD_X    = 5'd1;
   localparam mode_type MD_Y    = 5'd2;
   localparam mode_type MD_S    = 5'd3;
   localparam mode_type MD_P    = 5'd4;
   localparam mode_type MD_IMM  = 5'd5;
   localparam mode_type MD_IMP  = 5'd6;
   localparam mode_type MD_REL  = 5'd7;
   localparam mode_type MD_ZP   = 5'd8;
   localparam mode_type MD_ZPX  = 5'd9;
   localparam mode_type MD_ZPY  = 5'd10;
   localparam mode_type MD_ABS  = 5'd11;
   localparam mode_type MD_ABSX = 5'd12;
   localparam mode_type MD_ABSY = 5'd13;
   localparam mode_type MD_IND  = 5'd14;
   localparam mode_type MD_INDX = 5'd15;
   localparam mode_type MD_INDY = 5'd16;

   // Width of each stream payload, rounded up to whole bytes
   localparam int REQ_DATA_W = 32;
   localparam int RSP_DATA_W = 40;
   localparam int RSP_PAD_W  = 4;

   typedef struct packed {
      mnemonic_type mnemonic;
      mode_type     mode;
      cycles_type   cycles;
   } entry_type;

   // Last field in the lowest bits, as on req_tdata
   typedef struct packed {
      logic signed [7:0] operand_low;
      logic [15:0]       base_address;
      logic [7:0]        opcode;
   } req_type;

   // Last field in the lowest bits, as on rsp_tdata
   typedef struct packed {
      logic         is_known;
      logic [15:0]  branch_target;
      logic         is_conditional;
      logic         is_branch;
      logic         uses_memory;
      logic [1:0]   operand_bytes;
      cycles_type   cycle_count;
      mode_type     address_mode;
      mnemonic_type mnemonic_code;
   } result_type;

   function automatic entry_type ent(input mnemonic_type mn, input mode_type md,
                                     input cycles_type cy);
      entry_type e;
      e.mnemonic = mn;
      e.mode     = md;
      e.cycles   = cy;
      return e;
   endfunction

   function automatic entry_type lookup(input logic [7:0] op);
      entry_type e;
      case (op)
         8'h18: e = ent(MN_CLC, MD_IMP, 3'd2);
         8'h38: e = ent(MN_SEC, MD_IMP, 3'd2);
         8'h58: e = ent(MN_CLI, MD_IMP, 3'd2);
         8'h78: e = ent(MN_SEI, MD_IMP, 3'd2);
         8'hB8: e = ent(MN_CLV, MD_IMP, 3'd2);
         8'hD8: e = ent(MN_CLD, MD_IMP, 3'd2);
         8'hF8: e = ent(MN_SED, MD_IMP, 3'd2);
         8'h10: e = ent(MN_BPL, MD_REL, 3'd2);
         8'h30: e = ent(MN_BMI, MD_REL, 3'd2);
         8'h50: e = ent(MN_BVC, MD_REL, 3'd2);
         8'h70: e = ent(MN_BVS, MD_REL, 3'd2);
         8'h90: e = ent(MN_BCC, MD_REL, 3'd2);
         8'hB0: e = ent(MN_BCS, MD_REL, 3'd2);
         8'hD0: e = ent(MN_BNE, MD_REL, 3'd2);
         8'hF0: e = ent(MN_BEQ, MD_REL, 3'd2);
         8'hAA: e = ent(MN_TAX, MD_X, 3'd2);
         8'h8A: e = ent(MN_TXA, MD_ACC, 3'd2);
         8'hCA: e = ent(MN_DEX, MD_X, 3'd2);
         8'hE8: e = ent(MN_INX, MD_X, 3'd2);
         8'hA8: e = ent(MN_TAY, MD_Y, 3'd2);
         8'h98: e = ent(MN_TYA, MD_ACC, 3'd2);
         8'h88: e = ent(MN_DEY, MD_Y, 3'd2);
         8'hC8: e = ent(MN_INY, MD_Y, 3'd2);
         8'h9A: e = ent(MN_TXS, MD_S, 3'd2);
         8'hBA: e = ent(MN_TSX, MD_X, 3'd2);
         8'h48: e = ent(MN_PHA, MD_ACC, 3'd3);
         8'h68: e = ent(MN_PLA, MD_ACC, 3'd4);
         8'h08: e = ent(MN_PHP, MD_P, 3'd3);
         8'h28: e = ent(MN_PLP, MD_P, 3'd4);
         8'h4C: e = ent(MN_JMP, MD_ABS, 3'd3);
         8'h6C: e = ent(MN_JMP, MD_IND, 3'd5);
         8'h20: e = ent(MN_JSR, MD_ABS, 3'd6);
         8'h40: e = ent(MN_RTI, MD_IMP, 3'd6);
         8'h60: e = ent(MN_RTS, MD_IMP, 3'd6);
         8'h00: e = ent(MN_BRK, MD_IMM, 3'd7);
         8'h69: e = ent(MN_ADC, MD_IMM, 3'd2);
         8'h65: e = ent(MN_ADC, MD_ZP, 3'd3);
         8'h75: e = ent(MN_ADC, MD_ZPX, 3'd4);
         8'h6D: e = ent(MN_ADC, MD_ABS, 3'd4);
         8'h7D: e = ent(MN_ADC, MD_ABSX, 3'd4);
         8'h79: e = ent(MN_ADC, MD_ABSY, 3'd4);
         8'h61: e = ent(MN_ADC, MD_INDX, 3'd6);
         8'h71: e = ent(MN_ADC, MD_INDY, 3'd5);
         8'h29: e = ent(MN_AND, MD_IMM, 3'd2);
         8'h25: e = ent(MN_AND, MD_ZP, 3'd3);
         8'h35: e = ent(MN_AND, MD_ZPX, 3'd4);
         8'h2D: e = ent(MN_AND, MD_ABS, 3'd4);
         8'h3D: e = ent(MN_AND, MD_ABSX, 3'd4);
         8'h39: e = ent(MN_AND, MD_ABSY, 3'd4);
         8'h21: e = ent(MN_AND, MD_INDX, 3'd6);
         8'h31: e = ent(MN_AND, MD_INDY, 3'd5);
         8'h0A: e = ent(MN_ASL, MD_ACC, 3'd2);
         8'h06: e = ent(MN_ASL, MD_ZP, 3'd5);
         8'h16: e = ent(MN_ASL, MD_ZPX, 3'd6);
         8'h0E: e = ent(MN_ASL, MD_ABS, 3'd6);
         8'h1E: e = ent(MN_ASL, MD_ABSX, 3'd7);
         8'h24: e = ent(MN_BIT, MD_ZP, 3'd3);
         8'h2C: e = ent(MN_BIT, MD_ABS, 3'd4);
         8'hC9: e = ent(MN_CMP, MD_IMM, 3'd2);
         8'hC5: e = ent(MN_CMP, MD_ZP, 3'd3);
         8'hD5: e = ent(MN_CMP, MD_ZPX, 3'd4);
         8'hCD: e = ent(MN_CMP, MD_ABS, 3'd4);
         8'hDD: e = ent(MN_CMP, MD_ABSX, 3'd4);
         8'hD9: e = ent(MN_CMP, MD_ABSY, 3'd4);
         8'hC1: e = ent(MN_CMP, MD_INDX, 3'd6);
         8'hD1: e = ent(MN_CMP, MD_INDY, 3'd5);
         8'hE0: e = ent(MN_CPX, MD_IMM, 3'd2);
         8'hE4: e = ent(MN_CPX, MD_ZP, 3'd3);
         8'hEC: e = ent(MN_CPX, MD_ABS, 3'd4);
         8'hC0: e = ent(MN_CPY, MD_IMM, 3'd2);
         8'hC4: e = ent(MN_CPY, MD_ZP, 3'd3);
         8'hCC: e = ent(MN_CPY, MD_ABS, 3'd4);
         8'hC6: e = ent(MN_DEC, MD_ZP, 3'd5);
         8'hD6: e = ent(MN_DEC, MD_ZPX, 3'd6);
         8'hCE: e = ent(MN_DEC, MD_ABS, 3'd6);
         8'hDE: e = ent(MN_DEC, MD_ABSX, 3'd7);
         8'h49: e = ent(MN_EOR, MD_IMM, 3'd2);
         8'h45: e = ent(MN_EOR, MD_ZP, 3'd3);
         8'h55: e = ent(MN_EOR, MD_ZPX, 3'd4);
         8'h4D: e = ent(MN_EOR, MD_ABS, 3'd4);
         8'h5D: e = ent(MN_EOR, MD_ABSX, 3'd4);
         8'h59: e = ent(MN_EOR, MD_ABSY, 3'd4);
         8'h41: e = ent(MN_EOR, MD_INDX, 3'd6);
         8'h51: e = ent(MN_EOR, MD_INDY, 3'd5);
         8'hE6: e = ent(MN_INC, MD_ZP, 3'd5);
         8'hF6: e = ent(MN_INC, MD_ZPX, 3'd6);
         8'hEE: e = ent(MN_INC, MD_ABS, 3'd6);
         8'hFE: e = ent(MN_INC, MD_ABSX, 3'd7);
         8'hA9: e = ent(MN_LDA, MD_IMM, 3'd2);
         8'hA5: e = ent(MN_LDA, MD_ZP, 3'd3);
         8'hB5: e = ent(MN_LDA, MD_ZPX, 3'd4);
         8'hAD: e = ent(MN_LDA, MD_ABS, 3'd4);
         8'hBD: e = ent(MN_LDA, MD_ABSX, 3'd4);
         8'hB9: e = ent(MN_LDA, MD_ABSY, 3'd4);
         8'hA1: e = ent(MN_LDA, MD_INDX, 3'd6);
         8'hB1: e = ent(MN_LDA, MD_INDY, 3'd5);
         8'hA2: e = ent(MN_LDX, MD_IMM, 3'd2);
         8'hA6: e = ent(MN_LDX, MD_ZP, 3'd3);
         8'hB6: e = ent(MN_LDX, MD_ZPY, 3'd4);
         8'hAE: e = ent(MN_LDX, MD_ABS, 3'd4);
         8'hBE: e = ent(MN_LDX, MD_ABSY, 3'd4);
         8'hA0: e = ent(MN_LDY, MD_IMM, 3'd2);
         8'hA4: e = ent(MN_LDY, MD_ZP, 3'd3);
         8'hB4: e = ent(MN_LDY, MD_ZPX, 3'd4);
         8'hAC: e = ent(MN_LDY, MD_ABS, 3'd4);
         8'hBC: e = ent(MN_LDY, MD_ABSX, 3'd4);
         8'h4A: e = ent(MN_LSR, MD_ACC, 3'd2);
         8'h46: e = ent(MN_LSR, MD_ZP, 3'd5);
         8'h56: e = ent(MN_LSR, MD_ZPX, 3'd6);
         8'h4E: e = ent(MN_LSR, MD_ABS, 3'd6);
         8'h5E: e = ent(MN_LSR, MD_ABSX, 3'd7);
         // single-byte NOP aliases decode like the real NOP
         8'h1A, 8'h3A, 8'h5A, 8'h7A, 8'hDA, 8'hFA,
         8'hEA: e = ent(MN_NOP, MD_IMP, 3'd2);
         8'h09: e = ent(MN_ORA, MD_IMM, 3'd2);
         8'h05: e = ent(MN_ORA, MD_ZP, 3'd3);
         8'h15: e = ent(MN_ORA, MD_ZPX, 3'd4);
         8'h0D: e = ent(MN_ORA, MD_ABS, 3'd4);
         8'h1D: e = ent(MN_ORA, MD_ABSX, 3'd4);
         8'h19: e = ent(MN_ORA, MD_ABSY, 3'd4);
         8'h01: e = ent(MN_ORA, MD_INDX, 3'd6);
         8'h11: e = ent(MN_ORA, MD_INDY, 3'd5);
         8'h2A: e = ent(MN_ROL, MD_ACC, 3'd2);
         8'h26: e = ent(MN_ROL, MD_ZP, 3'd5);
         8'h36: e = ent(MN_ROL, MD_ZPX, 3'd6);
         8'h2E: e = ent(MN_ROL, MD_ABS, 3'd6);
         8'h3E: e = ent(MN_ROL, MD_ABSX, 3'd7);
         8'h6A: e = ent(MN_ROR, MD_ACC, 3'd2);
         8'h66: e = ent(MN_ROR, MD_ZP, 3'd5);
         8'h76: e = ent(MN_ROR, MD_ZPX, 3'd6);
         8'h6E: e = ent(MN_ROR, MD_ABS, 3'd6);
         8'h7E: e = ent(MN_ROR, MD_ABSX, 3'd7);
         // immediate SBC alias shares the documented encoding
         8'hEB,
         8'hE9: e = ent(MN_SBC, MD_IMM, 3'd2);
         8'hE5: e = ent(MN_SBC, MD_ZP, 3'd3);
         8'hF5: e = ent(MN_SBC, MD_ZPX, 3'd4);
         8'hED: e = ent(MN_SBC, MD_ABS, 3'd4);
         8'hFD: e = ent(MN_SBC, MD_ABSX, 3'd4);
         8'hF9: e = ent(MN_SBC, MD_ABSY, 3'd4);
         8'hE1: e = ent(MN_SBC, MD_INDX, 3'd6);
         8'hF1: e = ent(MN_SBC, MD_INDY, 3'd5);
         8'h85: e = ent(MN_STA, MD_ZP, 3'd3);
         8'h95: e = ent(MN_STA, MD_ZPX, 3'd4);
         8'h8D: e = ent(MN_STA, MD_ABS, 3'd4);
         8'h9D: e = ent(MN_STA, MD_ABSX, 3'd5);
         8'h99: e = ent(MN_STA, MD_ABSY, 3'd5);
         8'h81: e = ent(MN_STA, MD_INDX, 3'd6);
         8'h91: e = ent(MN_STA, MD_INDY, 3'd6);
         8'h86: e = ent(MN_STX, MD_ZP, 3'd3);
         8'h96: e = ent(MN_STX, MD_ZPY, 3'd4);
         8'h8E: e = ent(MN_STX, MD_ABS, 3'd4);
         8'h84: e = ent(MN_STY, MD_ZP, 3'd3);
         8'h94: e = ent(MN_STY, MD_ZPX, 3'd4);
         8'h8C: e = ent(MN_STY, MD_ABS, 3'd4);
         default: e = ent(MN_UNKNOWN, MD_IMP, 3'd1);
      endcase
      return e;
   endfunction

endpackage

### rtl/cpu6502dec_decode.sv
// ----------------------------------------------------------------------------
// cpu6502dec_decode
// Combinational decode of one registered request: table lookup, operand
// length, classification flags and relative branch target.
// ----------------------------------------------------------------------------
module cpu6502dec_decode (
   input  cpu6502dec_pkg::req_type    req,
   output cpu6502dec_pkg::result_type rsp
);
   import cpu6502dec_pkg::*;

   entry_type   entry;
   logic        cond;
   logic [15:0] offset_ext;

   assign entry      = lookup(req.opcode);
   assign offset_ext = {{8{req.operand_low[7]}}, req.operand_low};

   always_comb begin
      cond = entry.mnemonic inside {MN_BCC, MN_BCS, MN_BEQ, MN_BMI,
                                    MN_BNE, MN_BPL, MN_BVC, MN_BVS};

      rsp.mnemonic_code = entry.mnemonic;
      rsp.address_mode  = entry.mode;
      rsp.cycle_count   = entry.cycles;

      case (entry.mode)
         MD_IMM, MD_REL, MD_ZP, MD_ZPX, MD_ZPY, MD_INDX, MD_INDY: begin
            rsp.operand_bytes = 2'd1;
         end
         MD_ABS, MD_ABSX, MD_ABSY, MD_IND: begin
            rsp.operand_bytes = 2'd2;
         end
         default: begin
            rsp.operand_bytes = 2'd0;
         end
      endcase

      rsp.uses_memory    = entry.mode inside {[MD_ZP:MD_INDY]};
      // unknown opcodes are flagged as flow changes too
      rsp.is_branch      = cond || (entry.mnemonic inside {MN_UNKNOWN, MN_BRK, MN_JMP,
                                                           MN_JSR, MN_RTI, MN_RTS});
      rsp.is_conditional = cond;
      rsp.branch_target  = req.base_address + offset_ext;
      rsp.is_known       = (entry.mnemonic != MN_UNKNOWN);
   end

endmodule

### rtl/cpu6502_opcode_decoder.sv
// ----------------------------------------------------------------------------
// cpu6502_opcode_decoder
// 6502 opcode decoder on a pair of streams: one request carries an opcode,
// a base address and an operand byte, one response carries the decode.
// ----------------------------------------------------------------------------
// Path: the input register captures a request, the decode logic is combinational,
// and the output register loads the decode and raises rsp_tvalid.
// Throughput: one request per cycle; the input register, the decode logic
// and the output register form a two-stage pipeline that stalls only on
// rsp_tready.
// Reset: synchronous; clears both valid bits, payload registers keep data.
module cpu6502_opcode_decoder (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_tvalid,
   output logic                                  req_tready,
   input  logic [cpu6502dec_pkg::REQ_DATA_W-1:0] req_tdata,   // opcode, base_address,
                                                              // operand_low
   output logic                                  rsp_tvalid,
   input  logic                                  rsp_tready,
   output logic [cpu6502dec_pkg::RSP_DATA_W-1:0] rsp_tdata    // mnemonic_code,
                                                              // address_mode, cycle_count,
                                                              // operand_bytes, uses_memory,
                                                              // is_branch, is_conditional,
                                                              // branch_target, is_known
);
   import cpu6502dec_pkg::*;

   logic       in_valid_ff, in_valid_in;
   req_type    in_data_ff;
   logic       out_valid_ff, out_valid_in;
   result_type out_data_ff;
   result_type decoded;
   logic       out_ready;
   logic       in_ready;

   // output stage frees up when empty or when its transfer completes
   assign out_ready = !out_valid_ff || rsp_tready;
   assign in_ready  = !in_valid_ff || out_ready;

   assign in_valid_in  = req_tvalid || (in_valid_ff && !out_ready);
   assign out_valid_in = in_valid_ff || (out_valid_ff && !rsp_tready);

   cpu6502dec_decode u_decode (
      .req (in_data_ff),
      .rsp (decoded)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         if (in_ready) begin
            in_valid_ff <= in_valid_in;
         end
         if (out_ready) begin
            out_valid_ff <= out_valid_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (in_ready && req_tvalid) begin
         in_data_ff <= req_type'(req_tdata);
      end
      if (out_ready && in_valid_ff) begin
         out_data_ff <= decoded;
      end
   end

   assign req_tready = in_ready;
   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = {{RSP_PAD_W{1'b0}}, out_data_ff};

endmodule

### rtl/cpu6502dec_checker.sv
// ----------------------------------------------------------------------------
// cpu6502dec_checker
// Port-level checks for the opcode decoder, bound to the top level.
// ----------------------------------------------------------------------------
module cpu6502dec_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_tvalid,
   input logic        req_tready,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [39:0] rsp_tdata
);
   import cpu6502dec_pkg::*;

   result_type rsp;
   assign rsp = rsp_tdata[$bits(result_type)-1:0];

   // hold a stalled response
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("response dropped or changed while stalled");

   a_unknown: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp.is_known |->
         rsp.is_branch && rsp.mnemonic_code == MN_UNKNOWN && rsp.cycle_count == 3'd1
         && rsp.address_mode == MD_IMP && rsp.operand_bytes == 2'd0)
      else $error("unknown opcode decoded with wrong defaults");

   a_conditional: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp.is_conditional |->
         rsp.is_branch && rsp.address_mode == MD_REL && rsp.operand_bytes == 2'd1)
      else $error("conditional branch not relative");

   a_memory: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp.uses_memory |-> rsp.operand_bytes != 2'd0)
      else $error("memory mode without operand bytes");

   a_fill: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready && !rsp_tvalid |=> ##1 rsp_tvalid)
      else $error("request did not reach the response register");

endmodule

bind cpu6502_opcode_decoder cpu6502dec_checker u_checker (.*);

### tb/cpu6502_opcode_decoder_test.sv
// ----------------------------------------------------------------------------
// cpu6502_opcode_decoder_test
// Drives opcode/base/operand requests into the 6502 opcode decoder with
// random gaps and response stalls, predicts every decode from an opcode
// table built here, and checks each response in order against it.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module cpu6502_opcode_decoder_test;
   import cpu6502dec_pkg::*;

   localparam int RANDOM_ITEMS = 450;

   typedef struct packed {
      mnemonic_type mn;
      mode_type     md;
      cycles_type   cy;
   } table_row_type;

   typedef struct {
      req_type    request;
      result_type result;
   } decode_entry_type;

   logic        clock;
   logic        reset;
   logic        req_tvalid;
   logic        req_tready;
   logic [31:0] req_tdata;   // opcode, base_address, operand_low
   logic        rsp_tvalid;
   logic        rsp_tready;
   logic [39:0] rsp_tdata;   // mnemonic_code, address_mode, cycle_count,
                             // operand_bytes, uses_memory, is_branch,
                             // is_conditional, branch_target, is_known

   table_row_type    opcode_table [256];
   req_type          opcode_requests [$];
   decode_entry_type decode_expected [$];
   req_type          held_request;
   bit               opcode_seen [256];

   int unsigned total_requests;
   int unsigned accepted_requests;
   int unsigned checked_responses;
   int unsigned decode_errors;
   int unsigned known_decodes;
   int unsigned cond_decodes;
   int unsigned tx_gap, tx_calm;
   int unsigned rx_hold, rx_run, rx_calm;

   cpu6502_opcode_decoder dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   initial clock = 1'b0;
   always #2 clock = ~clock;

   // ---------------------------------------------------------------- table
   task automatic place(input logic [7:0] op, input mnemonic_type mn,
                        input mode_type md, input cycles_type cy);
      opcode_table[op] = '{mn: mn, md: md, cy: cy};
   endtask

   // Eight-mode ALU group: same low-bit pattern from each column base
   task automatic place_alu(input logic [7:0] col, input mnemonic_type mn);
      place(col + 8'h09, mn, MD_IMM, 3'd2);
      place(col + 8'h05, mn, MD_ZP, 3'd3);
      place(col + 8'h15, mn, MD_ZPX, 3'd4);
      place(col + 8'h0D, mn, MD_ABS, 3'd4);
      place(col + 8'h1D, mn, MD_ABSX, 3'd4);
      place(col + 8'h19, mn, MD_ABSY, 3'd4);
      place(col + 8'h01, mn, MD_INDX, 3'd6);
      place(col + 8'h11, mn, MD_INDY, 3'd5);
   endtask

   // Read-modify-write group; shifts and rotates also have an accumulator form
   task automatic place_rmw(input logic [7:0] col, input mnemonic_type mn,
                            input bit with_acc);
      if (with_acc) place(col + 8'h0A, mn, MD_ACC, 3'd2);
      place(col + 8'h06, mn, MD_ZP, 3'd5);
      place(col + 8'h16, mn, MD_ZPX, 3'd6);
      place(col + 8'h0E, mn, MD_ABS, 3'd6);
      place(col + 8'h1E, mn, MD_ABSX, 3'd7);
   endtask

   initial begin
      for (int i = 0; i < 256; i++) place(i[7:0], MN_UNKNOWN, MD_IMP, 3'd1);
      place_alu(8'h00, MN_ORA);
      place_alu(8'h20, MN_AND);
      place_alu(8'h40, MN_EOR);
      place_alu(8'h60, MN_ADC);
      place_alu(8'hA0, MN_LDA);
      place_alu(8'hC0, MN_CMP);
      place_alu(8'hE0, MN_SBC);
      place(8'hEB, MN_SBC, MD_IMM, 3'd2);
      place_rmw(8'h00, MN_ASL, 1'b1);
      place_rmw(8'h20, MN_ROL, 1'b1);
      place_rmw(8'h40, MN_LSR, 1'b1);
      place_rmw(8'h60, MN_ROR, 1'b1);
      place_rmw(8'hC0, MN_DEC, 1'b0);
      place_rmw(8'hE0, MN_INC, 1'b0);
      place(8'h85, MN_STA, MD_ZP, 3'd3);
      place(8'h95, MN_STA, MD_ZPX, 3'd4);
      place(8'h8D, MN_STA, MD_ABS, 3'd4);
      place(8'h9D, MN_STA, MD_ABSX, 3'd5);
      place(8'h99, MN_STA, MD_ABSY, 3'd5);
      place(8'h81, MN_STA, MD_INDX, 3'd6);
      place(8'h91, MN_STA, MD_INDY, 3'd6);
      place(8'h86, MN_STX, MD_ZP, 3'd3);
      place(8'h96, MN_STX, MD_ZPY, 3'd4);
      place(8'h8E, MN_STX, MD_ABS, 3'd4);
      place(8'h84, MN_STY, MD_ZP, 3'd3);
      place(8'h94, MN_STY, MD_ZPX, 3'd4);
      place(8'h8C, MN_STY, MD_ABS, 3'd4);
      place(8'hA2, MN_LDX, MD_IMM, 3'd2);
      place(8'hA6, MN_LDX, MD_ZP, 3'd3);
      place(8'hB6, MN_LDX, MD_ZPY, 3'd4);
      place(8'hAE, MN_LDX, MD_ABS, 3'd4);
      place(8'hBE, MN_LDX, MD_ABSY, 3'd4);
      place(8'hA0, MN_LDY, MD_IMM, 3'd2);
      place(8'hA4, MN_LDY, MD_ZP, 3'd3);
      place(8'hB4, MN_LDY, MD_ZPX, 3'd4);
      place(8'hAC, MN_LDY, MD_ABS, 3'd4);
      place(8'hBC, MN_LDY, MD_ABSX, 3'd4);
      place(8'hE0, MN_CPX, MD_IMM, 3'd2);
      place(8'hE4, MN_CPX, MD_ZP, 3'd3);
      place(8'hEC, MN_CPX, MD_ABS, 3'd4);
      place(8'hC0, MN_CPY, MD_IMM, 3'd2);
      place(8'hC4, MN_CPY, MD_ZP, 3'd3);
      place(8'hCC, MN_CPY, MD_ABS, 3'd4);
      place(8'h24, MN_BIT, MD_ZP, 3'd3);
      place(8'h2C, MN_BIT, MD_ABS, 3'd4);
      place(8'h10, MN_BPL, MD_REL, 3'd2);
      place(8'h30, MN_BMI, MD_REL, 3'd2);
      place(8'h50, MN_BVC, MD_REL, 3'd2);
      place(8'h70, MN_BVS, MD_REL, 3'd2);
      place(8'h90, MN_BCC, MD_REL, 3'd2);
      place(8'hB0, MN_BCS, MD_REL, 3'd2);
      place(8'hD0, MN_BNE, MD_REL, 3'd2);
      place(8'hF0, MN_BEQ, MD_REL, 3'd2);
      place(8'h00, MN_BRK, MD_IMM, 3'd7);
      place(8'h4C, MN_JMP, MD_ABS, 3'd3);
      place(8'h6C, MN_JMP, MD_IND, 3'd5);
      place(8'h20, MN_JSR, MD_ABS, 3'd6);
      place(8'h40, MN_RTI, MD_IMP, 3'd6);
      place(8'h60, MN_RTS, MD_IMP, 3'd6);
      place(8'h18, MN_CLC, MD_IMP, 3'd2);
      place(8'h38, MN_SEC, MD_IMP, 3'd2);
      place(8'h58, MN_CLI, MD_IMP, 3'd2);
      place(8'h78, MN_SEI, MD_IMP, 3'd2);
      place(8'hB8, MN_CLV, MD_IMP, 3'd2);
      place(8'hD8, MN_CLD, MD_IMP, 3'd2);
      place(8'hF8, MN_SED, MD_IMP, 3'd2);
      place(8'hEA, MN_NOP, MD_IMP, 3'd2);
      place(8'h1A, MN_NOP, MD_IMP, 3'd2);
      place(8'h3A, MN_NOP, MD_IMP, 3'd2);
      place(8'h5A, MN_NOP, MD_IMP, 3'd2);
      place(8'h7A, MN_NOP, MD_IMP, 3'd2);
      place(8'hDA, MN_NOP, MD_IMP, 3'd2);
      place(8'hFA, MN_NOP, MD_IMP, 3'd2);
      place(8'hAA, MN_TAX, MD_X, 3'd2);
      place(8'hA8, MN_TAY, MD_Y, 3'd2);
      place(8'hBA, MN_TSX, MD_X, 3'd2);
      place(8'h8A, MN_TXA, MD_ACC, 3'd2);
      place(8'h9A, MN_TXS, MD_S, 3'd2);
      place(8'h98, MN_TYA, MD_ACC, 3'd2);
      place(8'hCA, MN_DEX, MD_X, 3'd2);
      place(8'h88, MN_DEY, MD_Y, 3'd2);
      place(8'hE8, MN_INX, MD_X, 3'd2);
      place(8'hC8, MN_INY, MD_Y, 3'd2);
      place(8'h48, MN_PHA, MD_ACC, 3'd3);
      place(8'h68, MN_PLA, MD_ACC, 3'd4);
      place(8'h08, MN_PHP, MD_P, 3'd3);
      place(8'h28, MN_PLP, MD_P, 3'd4);
   end

   // ------------------------------------------------------------ predictor
   function automatic result_type decode_opcode(input req_type rq);
      result_type d;
      table_row_type row;
      row = opcode_table[rq.opcode];
      d.mnemonic_code = row.mn;
      d.address_mode  = row.md;
      d.cycle_count   = row.cy;
      case (row.md)
         MD_IMM, MD_REL, MD_ZP, MD_ZPX, MD_ZPY, MD_INDX, MD_INDY:
            d.operand_bytes = 2'd1;
         MD_ABS, MD_ABSX, MD_ABSY, MD_IND:
            d.operand_bytes = 2'd2;
         default:
            d.operand_bytes = 2'd0;
      endcase
      d.uses_memory = (row.md >= MD_ZP) && (row.md <= MD_INDY);
      case (row.mn)
         MN_BCC, MN_BCS, MN_BEQ, MN_BMI, MN_BNE, MN_BPL, MN_BVC, MN_BVS:
            d.is_conditional = 1'b1;
         default:
            d.is_conditional = 1'b0;
      endcase
      case (row.mn)
         MN_UNKNOWN, MN_BRK, MN_JMP, MN_JSR, MN_RTI, MN_RTS:
            d.is_branch = 1'b1;
         default:
            d.is_branch = d.is_conditional;
      endcase
      // target is computed for every opcode, wrapping at 16 bits
      d.branch_target = rq.base_address + {{8{rq.operand_low[7]}}, rq.operand_low};
      d.is_known = (row.mn != MN_UNKNOWN);
      return d;
   endfunction

   // Mostly back-to-back, some short gaps, a few long ones, and calm stretches
   function automatic int unsigned idle_length(inout int unsigned calm);
      int unsigned r;
      if (calm > 0) begin
         calm--;
         return 0;
      end
      r = $urandom_range(0, 99);
      if (r < 3) begin
         calm = $urandom_range(16, 48);
         return 0;
      end
      if (r < 45) return 0;
      if (r < 85) return $urandom_range(1, 3);
      if (r < 97) return $urandom_range(4, 12);
      return $urandom_range(20, 60);
   endfunction

   // ------------------------------------------------------------- stimulus
   task automatic queue_request(input logic [7:0] op, input logic [15:0] base,
                                input logic [7:0] ofs);
      req_type rq;
      rq.opcode       = op;
      rq.base_address = base;
      rq.operand_low  = ofs;
      opcode_requests.push_back(rq);
   endtask

   function automatic logic [15:0] pick_base();
      case ($urandom_range(0, 9))
         0:       return 16'(  $urandom_range(0, 127));
         1:       return 16'hFFFF - 16'($urandom_range(0, 127));
         default: return 16'($urandom);
      endcase
   endfunction

   initial begin
      logic [7:0] sweep [256];
      logic [7:0] swap;
      int unsigned j;

      reset      = 1'b1;
      req_tvalid = 1'b0;
      req_tdata  = '0;
      rsp_tready = 1'b0;

      // directed: extremes, most modes (not ZP, ZPX or ABSY), aliases and special encodings
      queue_request(8'h00, 16'h0000, 8'h00);  // BRK with immediate signature byte
      queue_request(8'hFF, 16'hFFFF, 8'h7F);  // unknown, target wraps forward
      queue_request(8'h02, 16'h0000, 8'h80);  // unknown, target wraps backward
      queue_request(8'h10, 16'h0000, 8'h80);
      queue_request(8'hF0, 16'hFFFF, 8'h7F);
      queue_request(8'h90, 16'h8000, 8'hFF);
      queue_request(8'h4C, 16'h1234, 8'h01);
      queue_request(8'h6C, 16'hABCD, 8'hFE);  // indirect JMP
      queue_request(8'h20, 16'h7FFF, 8'h01);
      queue_request(8'h40, 16'h0100, 8'h00);
      queue_request(8'h60, 16'h0200, 8'h55);
      queue_request(8'hEA, 16'h5555, 8'hAA);
      queue_request(8'h1A, 16'hAAAA, 8'h55);  // single-byte NOP alias
      queue_request(8'hEB, 16'h00FF, 8'h01);  // immediate SBC alias
      queue_request(8'h9D, 16'hFF00, 8'h00);
      queue_request(8'h91, 16'h00FF, 8'hFF);
      queue_request(8'h0A, 16'h0001, 8'h10);
      queue_request(8'hAA, 16'h0002, 8'h20);
      queue_request(8'hA8, 16'h0004, 8'h40);
      queue_request(8'h9A, 16'h0008, 8'h08);
      queue_request(8'h08, 16'h0010, 8'h04);
      queue_request(8'h18, 16'h0020, 8'h02);
      queue_request(8'hB6, 16'h0040, 8'h01);
      queue_request(8'h61, 16'h4000, 8'hC0);
      queue_request(8'h7E, 16'hC000, 8'h3F);

      // random: one pass over every opcode in shuffled order, then free draws
      for (int i = 0; i < 256; i++) sweep[i] = i[7:0];
      for (int i = 255; i > 0; i--) begin
         j = $urandom_range(0, i);
         swap = sweep[i];
         sweep[i] = sweep[j];
         sweep[j] = swap;
      end
      for (int i = 0; i < 256; i++)
         queue_request(sweep[i], pick_base(), 8'($urandom));
      for (int i = 256; i < RANDOM_ITEMS; i++)
         queue_request(8'($urandom), pick_base(), 8'($urandom));
      total_requests = opcode_requests.size();

      repeat (12) @(posedge clock);
      reset <= 1'b0;

      while (accepted_requests != total_requests) @(posedge clock);
      while (decode_expected.size() != 0) @(posedge clock);
      repeat (8) @(posedge clock);

      j = 0;
      for (int i = 0; i < 256; i++) if (opcode_seen[i]) j++;
      $display("decoded %0d requests over %0d distinct opcodes (%0d known, %0d unknown)",
               checked_responses, j, known_decodes, checked_responses - known_decodes);
      $display("%0d conditional branches, %0d decode errors", cond_decodes,
               decode_errors);
      if (decode_errors == 0) begin
         $display("SCOREBOARD CLEAN");
      end else begin
         $display("SCOREBOARD MISMATCH");
      end
      $finish;
   end

   // --------------------------------------------------------------- driver
   always @(posedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
         tx_gap = 0;
      end else begin
         if (req_tvalid && req_tready) begin
            decode_expected.push_back('{request: held_request,
                                        result: decode_opcode(held_request)});
            opcode_seen[held_request.opcode] = 1'b1;
            accepted_requests++;
         end
         // hold the current request until its transfer
         if (!req_tvalid || req_tready) begin
            if (tx_gap > 0) begin
               tx_gap--;
               req_tvalid <= 1'b0;
            end else if (opcode_requests.size() > 0) begin
               held_request = opcode_requests.pop_front();
               req_tdata  <= held_request;
               req_tvalid <= 1'b1;
               tx_gap = idle_length(tx_calm);
            end else begin
               req_tvalid <= 1'b0;
            end
         end
      end
   end

   // -------------------------------------------------------------- monitor
   always @(posedge clock) begin
      decode_entry_type want;
      result_type       got;
      if (reset) begin
         rsp_tready <= 1'b0;
         rx_hold = 0;
         rx_run  = 0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            got = rsp_tdata[$bits(result_type)-1:0];
            if (decode_expected.size() == 0) begin
               decode_errors++;
               if (decode_errors <= 10)
                  $display("unexpected response transfer, data %010h", rsp_tdata);
            end else begin
               want = decode_expected.pop_front();
               checked_responses++;
               if (want.result.is_known) known_decodes++;
               if (want.result.is_conditional) cond_decodes++;
               if (got !== want.result) begin
                  decode_errors++;
                  if (decode_errors <= 10)
                     $display({"op %02h base %04h ofs %02h: mnem %0d/%0d mode %0d/%0d ",
                               "cyc %0d/%0d len %0d/%0d mem %b/%b br %b/%b cond %b/%b ",
                               "tgt %04h/%04h known %b/%b (exp/got)"},
                              want.request.opcode, want.request.base_address,
                              want.request.operand_low,
                              want.result.mnemonic_code, got.mnemonic_code,
                              want.result.address_mode, got.address_mode,
                              want.result.cycle_count, got.cycle_count,
                              want.result.operand_bytes, got.operand_bytes,
                              want.result.uses_memory, got.uses_memory,
                              want.result.is_branch, got.is_branch,
                              want.result.is_conditional, got.is_conditional,
                              want.result.branch_target, got.branch_target,
                              want.result.is_known, got.is_known);
               end
            end
         end
         // ready for a short run, then drop it for a random stall
         if (rx_hold > 0) begin
            rx_hold--;
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= 1'b1;
            if (rx_run > 0) begin
               rx_run--;
            end else begin
               rx_run  = $urandom_range(0, 7);
               rx_hold = idle_length(rx_calm);
            end
         end
      end
   end

   // -------------------------------------------------------------- timeout
   initial begin
      #2_000_000;
      $display("timeout: %0d of %0d requests accepted, %0d responses pending",
               accepted_requests, total_requests, decode_expected.size());
      $display("SCOREBOARD MISMATCH");
      $finish;
   end

endmodule
